// ===== sv/dqbd_pkg.sv =====
// Package for the DMA queue budget dispatcher: word types, command and status
// structs, controller states, operation and status codes, record type decoder.
// No dependencies.
`default_nettype none

package dqbd_pkg;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_PALETTE = 2'd1;
	localparam logic [1:0] OP_BUDGET  = 2'd2;
	localparam logic [1:0] OP_PUBLISH = 2'd3;

	localparam logic [2:0] ST_ACCEPTED    = 3'd0;
	localparam logic [2:0] ST_COMPLETE    = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED   = 3'd2;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
	localparam logic [2:0] ST_RING_FULL   = 3'd4;

	localparam logic [7:0] TYPE_WORD      = 8'h01;
	localparam logic [7:0] TYPE_FILL      = 8'hFD;
	localparam logic [7:0] TYPE_FILL_HIGH = 8'hFC;
	localparam logic [7:0] TYPE_COLUMN    = 8'hD6;

	localparam logic [15:0] PALETTE_OVERHEAD = 16'h0050;
	localparam logic [7:0]  PORT_PALETTE     = 8'h22;
	localparam logic [7:0]  PORT_VRAM_LOW    = 8'h18;
	localparam logic [7:0]  PORT_VRAM_HIGH   = 8'h19;
	localparam logic [7:0]  INC_UNCHANGED    = 8'hFF;
	localparam logic [7:0]  INC_BYTE         = 8'h00;
	localparam logic [7:0]  INC_COLUMN       = 8'h81;
	localparam logic [3:0]  MODE_PALETTE     = 4'd0;
	localparam logic [3:0]  MODE_WORD        = 4'd1;
	localparam logic [3:0]  MODE_FIXED       = 4'd8;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  record_type;
		logic [23:0] job_source;
		logic [15:0] job_size;
		logic [15:0] job_destination;
		logic [15:0] budget_value;
	} dqbd_in_t;

	typedef struct packed {
		logic        is_transfer;
		logic [3:0]  transfer_mode;
		logic [7:0]  bbus_port;
		logic [7:0]  vram_increment;
		logic [23:0] transfer_source;
		logic [15:0] transfer_size;
		logic [15:0] transfer_destination;
		logic [2:0]  status;
		logic        last;
	} dqbd_out_t;

	typedef struct packed {
		logic [7:0]  rtype;
		logic [23:0] source;
		logic [15:0] size;
		logic [15:0] destination;
	} dqbd_rec_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] overhead;
		logic [3:0] mode;
		logic [7:0] port;
		logic [7:0] inc;
	} dqbd_dec_t;

	typedef struct packed {
		logic setup;
		logic pub_start;
		logic palette;
		logic walk;
	} dqbd_cmd_t;

	typedef struct packed {
		logic walk_end;
	} dqbd_stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PALETTE,
		S_WALK
	} dqbd_state_t;

	function automatic dqbd_dec_t dqbd_decode(input logic [7:0] rtype);
		dqbd_dec_t d;
		d.ok       = 1'b1;
		d.overhead = 8'h6C;
		d.mode     = MODE_WORD;
		d.port     = PORT_VRAM_LOW;
		d.inc      = INC_UNCHANGED;
		case (rtype)
			TYPE_WORD: begin
				d.overhead = 8'h6C;
			end
			TYPE_FILL: begin
				d.overhead = 8'h78;
				d.mode     = MODE_FIXED;
				d.inc      = INC_BYTE;
			end
			TYPE_FILL_HIGH: begin
				d.overhead = 8'h77;
				d.mode     = MODE_FIXED;
				d.port     = PORT_VRAM_HIGH;
			end
			TYPE_COLUMN: begin
				d.overhead = 8'h8A;
				d.inc      = INC_COLUMN;
			end
			default: begin
				d.ok = 1'b0;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== sv/dma_queue_budget_dispatch.sv =====
// Top level of the DMA queue budget dispatcher: joins controller and datapath.
// Depends on dqbd_pkg, dqbd_ctrl and dqbd_dp.
//
// Use: drive item and raise start; the word is taken at a rising edge with
// start high and busy low. Every result appears on result for one cycle with
// result_strobe high; the receiver takes it at the edge that ends that cycle
// and cannot hold it off.
// Push, palette and budget words: one result, registered in the cycle after
// the accept; busy stays low, so a new word may follow every cycle.
// Publish: busy until the walk ends; up to RING_ENTRIES - 1 records are
// walked, and the ring memory's registered read port delivers one record
// a cycle, with the next address read ahead. Results trail the walk, each
// transfer being held until the next decision fixes its status;
// the final result carries last and the status.
// Reset: asynchronous, active low; indices, budget and palette job clear at
// once, the ring needs no clearing pass and is ready in the first cycle.
`default_nettype none

module dma_queue_budget_dispatch import dqbd_pkg::*; #(
	parameter int RING_ENTRIES = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire dqbd_in_t item,
	output dqbd_out_t     result,
	output logic          result_strobe
);

	dqbd_cmd_t  cmd;
	dqbd_stat_t stat;

	dqbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	dqbd_dp #(
		.RING_ENTRIES (RING_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.stat          (stat),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

`default_nettype wire

// ===== sv/dqbd_ctrl.sv =====
// Controller for the DMA queue budget dispatcher: sequences setup words and
// the publish walk. Depends on dqbd_pkg.
`default_nettype none

module dqbd_ctrl import dqbd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] operation,
	input  wire dqbd_stat_t stat,
	output dqbd_cmd_t       cmd,
	output logic            busy
);

	dqbd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		busy          = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (operation == OP_PUBLISH) begin
						cmd.pub_start = 1'b1;
						state_d       = S_PALETTE;
					end else begin
						cmd.setup = 1'b1;
					end
				end
			end
			S_PALETTE: begin
				cmd.palette = 1'b1;
				state_d     = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_end) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/dqbd_dp.sv =====
// Datapath for the DMA queue budget dispatcher: record ring memory, indices,
// budget, palette job, held transfer and result register. Depends on dqbd_pkg.
`default_nettype none

module dqbd_dp import dqbd_pkg::*; #(
	parameter int RING_ENTRIES = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dqbd_in_t  item,
	input  wire dqbd_cmd_t cmd,
	output dqbd_stat_t     stat,
	output dqbd_out_t      result,
	output logic           result_strobe
);

	localparam int IW = $clog2(RING_ENTRIES);
	localparam logic [IW-1:0] LAST_SLOT = IW'(RING_ENTRIES - 1);

	dqbd_rec_t     ring [RING_ENTRIES];
	dqbd_rec_t     rd_q;
	logic [IW-1:0] rd_addr;

	logic [IW-1:0] head_q, tail_q, cursor_q;
	logic [15:0]   budget_q;
	logic [23:0]   pal_source_q;
	logic [15:0]   pal_size_q;
	logic [7:0]    pal_dest_q;
	dqbd_out_t     pend_q;
	logic          pend_valid_q;
	dqbd_out_t     out_q;
	logic          strobe_q;

	logic [IW-1:0] cursor_next, tail_next;
	logic          ring_full, at_tail, short;
	logic [16:0]   need;
	dqbd_dec_t     dec;
	dqbd_out_t     xfer, fin;
	logic [2:0]    fin_status;
	logic          pal_borrow;

	assign cursor_next = (cursor_q == LAST_SLOT) ? '0 : cursor_q + 1'b1;
	assign tail_next   = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
	assign ring_full   = (tail_next == head_q);
	assign at_tail     = (cursor_q == tail_q);
	assign dec         = dqbd_decode(rd_q.rtype);
	assign need        = {1'b0, rd_q.size} + 17'(dec.overhead);
	assign short       = ({1'b0, budget_q} < need);
	assign pal_borrow  = (budget_q < pal_size_q);
	assign rd_addr     = cmd.walk ? cursor_next : head_q;

	assign stat.walk_end = at_tail | ~dec.ok | short;

	always_comb begin
		xfer                      = '0;
		xfer.is_transfer          = 1'b1;
		xfer.transfer_mode        = dec.mode;
		xfer.bbus_port            = dec.port;
		xfer.vram_increment       = dec.inc;
		xfer.transfer_source      = rd_q.source;
		xfer.transfer_size        = rd_q.size;
		xfer.transfer_destination = rd_q.destination;
		xfer.status               = ST_ACCEPTED;
		xfer.last                 = 1'b0;
	end

	always_comb begin
		if (at_tail) begin
			fin_status = ST_COMPLETE;
		end else if (!dec.ok) begin
			fin_status = ST_UNSUPPORTED;
		end else begin
			fin_status = ST_EXHAUSTED;
		end
		fin        = pend_valid_q ? pend_q : '0;
		fin.status = fin_status;
		fin.last   = 1'b1;
	end

	always_ff @(posedge clk) begin
		rd_q <= ring[rd_addr];
		if (cmd.setup && item.operation == OP_PUSH && !ring_full) begin
			ring[tail_q] <= '{rtype:       item.record_type,
			                  source:      item.job_source,
			                  size:        item.job_size,
			                  destination: item.job_destination};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			cursor_q     <= '0;
			budget_q     <= '0;
			pal_source_q <= '0;
			pal_size_q   <= '0;
			pal_dest_q   <= '0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.setup) begin
				strobe_q <= 1'b1;
				case (item.operation)
					OP_PUSH: begin
						if (!ring_full) begin
							tail_q <= tail_next;
						end
					end
					OP_PALETTE: begin
						pal_source_q <= item.job_source;
						pal_size_q   <= item.job_size;
						pal_dest_q   <= item.job_destination[7:0];
					end
					OP_BUDGET: begin
						budget_q <= item.budget_value;
					end
					default: begin
					end
				endcase
			end
			if (cmd.pub_start) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.palette) begin
				cursor_q <= head_q;
				if (pal_size_q[7:0] != 8'h00) begin
					budget_q     <= budget_q - pal_size_q - PALETTE_OVERHEAD
					                - 16'(pal_borrow);
					pal_size_q   <= '0;
					pend_valid_q <= 1'b1;
				end
			end
			if (cmd.walk) begin
				if (stat.walk_end) begin
					strobe_q     <= 1'b1;
					pend_valid_q <= 1'b0;
					if (at_tail || (dec.ok && short)) begin
						head_q <= cursor_q;
					end
				end else begin
					budget_q     <= budget_q - 16'(dec.overhead) - rd_q.size;
					cursor_q     <= cursor_next;
					pend_valid_q <= 1'b1;
					strobe_q     <= pend_valid_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			out_q        <= '0;
			out_q.status <= (item.operation == OP_PUSH && ring_full) ?
			                ST_RING_FULL : ST_ACCEPTED;
			out_q.last   <= 1'b1;
		end
		if (cmd.palette && pal_size_q[7:0] != 8'h00) begin
			pend_q                      <= '0;
			pend_q.is_transfer          <= 1'b1;
			pend_q.transfer_mode        <= MODE_PALETTE;
			pend_q.bbus_port            <= PORT_PALETTE;
			pend_q.vram_increment       <= INC_UNCHANGED;
			pend_q.transfer_source      <= pal_source_q;
			pend_q.transfer_size        <= pal_size_q;
			pend_q.transfer_destination <= {8'h00, pal_dest_q};
		end
		if (cmd.walk) begin
			if (stat.walk_end) begin
				out_q <= fin;
			end else begin
				out_q  <= pend_q;
				pend_q <= xfer;
			end
		end
	end

	assign result        = out_q;
	assign result_strobe = strobe_q;

`ifndef ASSERT_OFF
	a_setup_answers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup |=> result_strobe && result.last && !result.is_transfer)
		else $error("setup word gave no single final result");
	a_inner_is_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> result.is_transfer
		&& result.status == ST_ACCEPTED)
		else $error("non-final result without transfer");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |=> result_strobe)
		else $error("publish run broke off before its final result");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.is_transfer |-> result.transfer_size == 16'h0000
		&& result.transfer_source == 24'h000000 && result.bbus_port == 8'h00)
		else $error("non-transfer result carries transfer fields");
`endif

endmodule

`default_nettype wire
